// ===== design/cfc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types, constants and mod-255 helpers for the header checksum block.
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int unsigned ChecksumPosDefault = 7;
  localparam int unsigned MaxHeaderLenDefault = 255;
  localparam int unsigned OctetW = 8;
  localparam int unsigned QueueDepth = 2;
  localparam logic [OctetW-1:0] ModValue = 8'd255;

  typedef enum logic {
    CMD_GENERATE = 1'b0,
    CMD_VERIFY   = 1'b1
  } cmd_e;

  // One finished header, handed from the front to the back.
  typedef struct packed {
    cmd_e              mode;
    logic [OctetW-1:0] len;
    logic [OctetW-1:0] sum_low;
    logic [OctetW-1:0] sum_high;
    logic              verify_ok;
  } job_t;

  // a in 0..254, b in 0..255: one conditional subtract is enough.
  function automatic logic [OctetW-1:0] add_mod(logic [OctetW-1:0] a, logic [OctetW-1:0] b);
    logic [OctetW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, ModValue}) begin
      s = s - {1'b0, ModValue};
    end
    return s[OctetW-1:0];
  endfunction

  // 16-bit value mod 255: fold the bytes twice, since 256 is 1 mod 255.
  function automatic logic [OctetW-1:0] mod255_16(logic [2*OctetW-1:0] v);
    logic [OctetW:0] t;
    logic [OctetW:0] u;
    t = {1'b0, v[2*OctetW-1:OctetW]} + {1'b0, v[OctetW-1:0]};
    u = {{OctetW{1'b0}}, t[OctetW]} + {1'b0, t[OctetW-1:0]};
    if (u >= {1'b0, ModValue}) begin
      u = u - {1'b0, ModValue};
    end
    return u[OctetW-1:0];
  endfunction

endpackage

// ===== design/clnp_fletcher_checksum.sv =====
// ----------------------------------------------------------------------------
// clnp_fletcher_checksum
// Header checksum, mod-255 Fletcher sums: generate X/Y or verify, one octet
// per word.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o   | cmd_i, data_byte_i, last_i
//   out     | output    | out_valid_o / out_ready_i | first_octet_o, second_octet_o,
//           |           |                           | check_ok_o
//
// Takes one octet per cycle while in_ready_o is high; the running sums are
// updated in the intake cycle. A result word passes through the queue slot
// written at the edge that takes its final octet, then the product stage,
// then the output register. in_ready_o falls only while the two-entry job
// queue is full, i.e. when the output has been stalled across several headers.
// Reset clears the sums, octet count, queue and pipeline valid flags.
// ----------------------------------------------------------------------------
module clnp_fletcher_checksum import cfc_pkg::*; #(
  parameter int unsigned CHECKSUM_POS   = ChecksumPosDefault,
  parameter int unsigned MAX_HEADER_LEN = MaxHeaderLenDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [OctetW-1:0] data_byte_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OctetW-1:0] first_octet_o,
  output logic [OctetW-1:0] second_octet_o,
  output logic              check_ok_o
);

  logic accept, push, pop, full, empty;
  job_t job_in, job_out;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  cfc_front #(
    .CHECKSUM_POS  (CHECKSUM_POS),
    .MAX_HEADER_LEN(MAX_HEADER_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (cmd_i),
    .data_byte_i(data_byte_i),
    .last_i     (last_i),
    .push_o     (push),
    .job_o      (job_in)
  );

  cfc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .full_o (full),
    .empty_o(empty),
    .job_o  (job_out)
  );

  cfc_back #(
    .CHECKSUM_POS(CHECKSUM_POS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .job_i         (job_out),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .first_octet_o (first_octet_o),
    .second_octet_o(second_octet_o),
    .check_ok_o    (check_ok_o)
  );

endmodule

// ===== design/cfc_front.sv =====
// ----------------------------------------------------------------------------
// cfc_front
// Byte intake: keeps the running Fletcher sums and octet count, classifies
// the checksum positions and posts one job per header on its final octet.
// ----------------------------------------------------------------------------
module cfc_front import cfc_pkg::*; #(
  parameter int unsigned CHECKSUM_POS   = ChecksumPosDefault,
  parameter int unsigned MAX_HEADER_LEN = MaxHeaderLenDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              cmd_i,
  input  logic [OctetW-1:0] data_byte_i,
  input  logic              last_i,
  output logic              push_o,
  output job_t              job_o
);

  logic [OctetW-1:0] sum_low_q, sum_low_d;
  logic [OctetW-1:0] sum_high_q, sum_high_d;
  logic [OctetW-1:0] count_q, count_d;
  cmd_e              mode_q, mode_d;
  logic              first_zero_q, first_zero_d;
  logic              second_zero_q, second_zero_d;

  logic              head;
  logic [OctetW-1:0] sl_base, sh_base, octet_v, cnt_new, sl_new, sh_new;
  logic              fz_new, sz_new;

  always_comb begin
    head    = (count_q == '0);
    mode_d  = head ? cmd_e'(cmd_i) : mode_q;
    sl_base = head ? '0 : sum_low_q;
    sh_base = head ? '0 : sum_high_q;
    fz_new  = head ? 1'b1 : first_zero_q;
    sz_new  = head ? 1'b1 : second_zero_q;
    sl_new  = sl_base;
    sh_new  = sh_base;
    cnt_new = count_q;
    octet_v = data_byte_i;
    if (count_q < OctetW'(MAX_HEADER_LEN)) begin
      if (count_q == OctetW'(CHECKSUM_POS)) begin
        fz_new = (data_byte_i == '0);
        if (mode_d == CMD_GENERATE) octet_v = '0;
      end else if ({1'b0, count_q} == (OctetW+1)'(CHECKSUM_POS + 1)) begin
        sz_new = (data_byte_i == '0);
        if (mode_d == CMD_GENERATE) octet_v = '0;
      end
      sl_new  = add_mod(sl_base, octet_v);
      sh_new  = add_mod(sh_base, sl_new);
      cnt_new = count_q + 1'b1;
    end

    job_o.mode      = mode_d;
    job_o.len       = cnt_new;
    job_o.sum_low   = sl_new;
    job_o.sum_high  = sh_new;
    job_o.verify_ok = ({1'b0, cnt_new} >= (OctetW+1)'(CHECKSUM_POS + 2))
                      && ((fz_new && sz_new)
                          || (!fz_new && !sz_new && sl_new == '0 && sh_new == '0));
    push_o = accept_i && last_i;

    // drop the sums, octet count and zero flags once the final octet is in
    sum_low_d     = sum_low_q;
    sum_high_d    = sum_high_q;
    count_d       = count_q;
    first_zero_d  = first_zero_q;
    second_zero_d = second_zero_q;
    if (accept_i) begin
      if (last_i) begin
        sum_low_d     = '0;
        sum_high_d    = '0;
        count_d       = '0;
        first_zero_d  = 1'b1;
        second_zero_d = 1'b1;
      end else begin
        sum_low_d     = sl_new;
        sum_high_d    = sh_new;
        count_d       = cnt_new;
        first_zero_d  = fz_new;
        second_zero_d = sz_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_low_q     <= '0;
      sum_high_q    <= '0;
      count_q       <= '0;
      mode_q        <= CMD_GENERATE;
      first_zero_q  <= 1'b1;
      second_zero_q <= 1'b1;
    end else begin
      sum_low_q     <= sum_low_d;
      sum_high_q    <= sum_high_d;
      count_q       <= count_d;
      first_zero_q  <= first_zero_d;
      second_zero_q <= second_zero_d;
      if (accept_i) mode_q <= mode_d;
    end
  end

  a_sums_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_low_q != ModValue) && (sum_high_q != ModValue))
    else $error("running sum left the 0..254 range");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, count_q} <= (OctetW+1)'(MAX_HEADER_LEN))
    else $error("octet count passed the header limit");

endmodule

// ===== design/cfc_queue.sv =====
// ----------------------------------------------------------------------------
// cfc_queue
// Short job queue between intake and finishing, flip-flop storage.
// ----------------------------------------------------------------------------
module cfc_queue import cfc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output job_t job_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q;
  logic            do_push, do_pop;

  assign full_o  = (fill_q == CntW'(QueueDepth));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = slot_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      unique case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(QueueDepth))
    else $error("queue fill above depth");

endmodule

// ===== design/cfc_back.sv =====
// ----------------------------------------------------------------------------
// cfc_back
// Finishing pipeline: length weights and products, then mod-255 reduction
// into the registered result word (generate); verify passes on the check flag.
// ----------------------------------------------------------------------------
module cfc_back import cfc_pkg::*; #(
  parameter int unsigned CHECKSUM_POS = ChecksumPosDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  job_t              job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OctetW-1:0] first_octet_o,
  output logic [OctetW-1:0] second_octet_o,
  output logic              check_ok_o
);

  logic                s1_valid_q, out_valid_q, advance;
  logic [2*OctetW-1:0] prod_x_q, prod_y_q;
  logic [OctetW-1:0]   s1_sum_high_q;
  cmd_e                s1_mode_q;
  logic                s1_ok_q;
  logic [OctetW-1:0]   first_q, second_q;
  logic                ok_q;

  logic [OctetW:0]     kx_wide;
  logic [OctetW-1:0]   kx, ky, x_red, y_red;

  assign advance = !out_valid_q || out_ready_i;
  assign pop_o   = advance && !empty_i;

  always_comb begin
    // (L - n) mod 255 with n = CHECKSUM_POS + 1, kept non-negative
    kx_wide = {1'b0, job_i.len} + {1'b0, ModValue} - (OctetW+1)'(CHECKSUM_POS + 1);
    if (kx_wide >= {1'b0, ModValue}) kx_wide = kx_wide - {1'b0, ModValue};
    kx = kx_wide[OctetW-1:0];
    ky = (kx == ModValue - 1'b1) ? '0 : kx + 1'b1;
    x_red = mod255_16(prod_x_q + {{OctetW{1'b0}}, ModValue - s1_sum_high_q});
    y_red = mod255_16(prod_y_q + {{OctetW{1'b0}}, s1_sum_high_q});
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      prod_x_q      <= kx * job_i.sum_low;
      prod_y_q      <= ky * (ModValue - job_i.sum_low);
      s1_sum_high_q <= job_i.sum_high;
      s1_mode_q     <= job_i.mode;
      s1_ok_q       <= job_i.verify_ok;
      if (s1_mode_q == CMD_GENERATE) begin
        first_q  <= (x_red == '0) ? ModValue : x_red;
        second_q <= (y_red == '0) ? ModValue : y_red;
        ok_q     <= 1'b1;
      end else begin
        first_q  <= '0;
        second_q <= '0;
        ok_q     <= s1_ok_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= !empty_i;
      out_valid_q <= s1_valid_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign first_octet_o  = first_q;
  assign second_octet_o = second_q;
  assign check_ok_o     = ok_q;

  a_octets_paired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((first_q == '0) == (second_q == '0)))
    else $error("one checksum octet zero, the other not");

  a_zero_means_verify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && first_q == '0) |-> ((second_q == '0) || ok_q))
    else $error("verify result carries generated octets");

endmodule
